FILE: sv/ejf_pkg.sv
// Shared types, register codes and helpers for the elastic joint force block.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package ejf_pkg;

    localparam int unsigned SQRT_STAGES = 32;
    localparam int unsigned DIV_STAGES  = 32;
    localparam int unsigned LATENCY     = 3 + SQRT_STAGES + 7 + 1 + DIV_STAGES + 1;

    localparam logic [2:0] REG_REST_RADIUS = 3'd0;
    localparam logic [2:0] REG_COEF_CUBIC  = 3'd1;
    localparam logic [2:0] REG_COEF_QUAD   = 3'd2;
    localparam logic [2:0] REG_COEF_LIN    = 3'd3;
    localparam logic [2:0] REG_COEF_CONST  = 3'd4;

    typedef struct packed {
        logic signed [31:0] point_a_x;
        logic signed [31:0] point_a_y;
        logic signed [31:0] point_a_z;
        logic signed [31:0] point_b_x;
        logic signed [31:0] point_b_y;
        logic signed [31:0] point_b_z;
    } in_t;

    typedef struct packed {
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
        logic               active;
        logic               saturated;
    } out_t;

    typedef struct packed {
        logic [30:0]        rest;
        logic signed [31:0] cubic;
        logic signed [31:0] quad;
        logic signed [31:0] lin;
        logic signed [31:0] cst;
    } cfg_t;

    typedef struct packed {
        logic [2:0][30:0] mag;
        logic [2:0]       neg;
        logic             big;
        logic             active;
    } geo_t;

    typedef struct packed {
        logic [2:0][30:0]   mag;
        logic [2:0]         neg;
        logic               active;
        logic               sat;
        logic [31:0]        len;
        logic [30:0]        r;
        logic signed [31:0] acc;
    } pol_t;

    typedef struct packed {
        logic [2:0][31:0] q;
        logic [2:0]       neg;
        logic             active;
        logic             sat;
    } frc_t;

    // Bit 32 flags a clamp, bits 31:0 hold the clamped value.
    function automatic logic [32:0] sat32(input logic [48:0] v);
        logic [32:0] res;
        if (v[48:31] != {18{v[48]}})
        begin
            res = {1'b1, (v[48] ? 32'h8000_0000 : 32'h7FFF_FFFF)};
        end
        else
        begin
            res = {1'b0, v[31:0]};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: sv/ejf_front.sv
// Front stages: differences, magnitudes, squares, sum of squares, rest compare.
// Depends on ejf_pkg.
`default_nettype none

module ejf_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  ejf_pkg::in_t  item,
    input  logic [30:0]   rest_radius,
    output logic          out_valid,
    output ejf_pkg::geo_t geo,
    output logic [63:0]   sum
);

    logic [32:0]      diff [3];
    logic [32:0]      mag_full [3];
    logic [2:0]       neg_d;
    logic             big;
    logic [2:0][30:0] mag_s;

    logic             v1_reg;
    logic [2:0][30:0] mag1_reg;
    logic [2:0]       neg1_reg;
    logic             big1_reg;

    logic             v2_reg;
    logic [61:0]      sq2_reg [3];
    logic [61:0]      rr2_reg;
    logic [2:0][30:0] mag2_reg;
    logic [2:0]       neg2_reg;
    logic             big2_reg;

    logic [63:0]      sum_next;
    logic             v3_reg;
    logic [63:0]      sum3_reg;
    ejf_pkg::geo_t    geo3_reg;

    always_comb
    begin
        diff[0] = {item.point_b_x[31], item.point_b_x} - {item.point_a_x[31], item.point_a_x};
        diff[1] = {item.point_b_y[31], item.point_b_y} - {item.point_a_y[31], item.point_a_y};
        diff[2] = {item.point_b_z[31], item.point_b_z} - {item.point_a_z[31], item.point_a_z};
        big = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            neg_d[i]    = diff[i][32];
            mag_full[i] = diff[i][32] ? (~diff[i] + 33'd1) : diff[i];
            big         = big | (|mag_full[i][32:31]);
        end
        for (int i = 0; i < 3; i++)
        begin
            mag_s[i] = big ? mag_full[i][32:2] : mag_full[i][30:0];
        end
        sum_next = 64'(sq2_reg[0]) + 64'(sq2_reg[1]) + 64'(sq2_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mag1_reg <= mag_s;
        neg1_reg <= neg_d;
        big1_reg <= big;

        for (int i = 0; i < 3; i++)
        begin
            sq2_reg[i] <= 62'(mag1_reg[i]) * 62'(mag1_reg[i]);
        end
        rr2_reg  <= 62'(rest_radius) * 62'(rest_radius);
        mag2_reg <= mag1_reg;
        neg2_reg <= neg1_reg;
        big2_reg <= big1_reg;

        sum3_reg        <= sum_next;
        geo3_reg.mag    <= mag2_reg;
        geo3_reg.neg    <= neg2_reg;
        geo3_reg.big    <= big2_reg;
        geo3_reg.active <= big2_reg | (sum_next > {2'b00, rr2_reg});
    end

    assign out_valid = v3_reg;
    assign geo       = geo3_reg;
    assign sum       = sum3_reg;

endmodule

`default_nettype wire

FILE: sv/ejf_sqrt.sv
// Pipelined integer square root, one result bit per stage, geometry carried along.
// Depends on ejf_pkg.
`default_nettype none

module ejf_sqrt (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [63:0]   sum,
    input  ejf_pkg::geo_t geo_in,
    output logic          out_valid,
    output logic [31:0]   len,
    output ejf_pkg::geo_t geo_out
);

    localparam int unsigned N = ejf_pkg::SQRT_STAGES;

    logic          v_reg    [N];
    logic [33:0]   rem_reg  [N];
    logic [31:0]   root_reg [N];
    logic [63:0]   num_reg  [N];
    ejf_pkg::geo_t side_reg [N];

    for (genvar k = 0; k < N; k++)
    begin : g_stage
        logic          v_prev;
        logic [33:0]   rem_prev;
        logic [31:0]   root_prev;
        logic [63:0]   num_prev;
        ejf_pkg::geo_t side_prev;
        logic [35:0]   rem_sh;
        logic [35:0]   trial;
        logic [35:0]   delta;
        logic          ge;

        if (k == 0)
        begin : g_first
            assign v_prev    = in_valid;
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign num_prev  = sum;
            assign side_prev = geo_in;
        end
        else
        begin : g_next
            assign v_prev    = v_reg[k-1];
            assign rem_prev  = rem_reg[k-1];
            assign root_prev = root_reg[k-1];
            assign num_prev  = num_reg[k-1];
            assign side_prev = side_reg[k-1];
        end

        assign rem_sh = {rem_prev, num_prev[63:62]};
        assign trial  = {2'b00, root_prev, 2'b01};
        assign delta  = rem_sh - trial;
        assign ge     = rem_sh >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else
            begin
                v_reg[k] <= v_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k]  <= ge ? delta[33:0] : rem_sh[33:0];
            root_reg[k] <= {root_prev[30:0], ge};
            num_reg[k]  <= {num_prev[61:0], 2'b00};
            side_reg[k] <= side_prev;
        end
    end

    assign out_valid = v_reg[N-1];
    assign len       = root_reg[N-1];
    assign geo_out   = side_reg[N-1];

endmodule

`default_nettype wire

FILE: sv/ejf_horner.sv
// Distance clamp and three Horner steps, each a multiply stage and an add stage.
// Depends on ejf_pkg.
`default_nettype none

module ejf_horner (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [31:0]   len,
    input  ejf_pkg::geo_t geo,
    input  ejf_pkg::cfg_t cfg,
    output logic          out_valid,
    output ejf_pkg::pol_t pol
);

    logic [33:0]        r_wide;
    logic               r_clamp;
    logic signed [31:0] coefs [3];

    logic               b_v_reg;
    ejf_pkg::pol_t      b_pol_reg;

    logic               m_v_reg    [3];
    ejf_pkg::pol_t      m_pol_reg  [3];
    logic signed [63:0] m_prod_reg [3];
    logic               a_v_reg    [3];
    ejf_pkg::pol_t      a_pol_reg  [3];

    assign r_wide   = geo.big ? {len, 2'b00} : {2'b00, len};
    assign r_clamp  = r_wide > 34'h0_7FFF_FFFF;
    assign coefs[0] = cfg.quad;
    assign coefs[1] = cfg.lin;
    assign coefs[2] = cfg.cst;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_v_reg <= 1'b0;
        end
        else
        begin
            b_v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        b_pol_reg.mag    <= geo.mag;
        b_pol_reg.neg    <= geo.neg;
        b_pol_reg.active <= geo.active;
        b_pol_reg.sat    <= geo.big | r_clamp;
        b_pol_reg.len    <= len;
        b_pol_reg.r      <= r_clamp ? 31'h7FFF_FFFF : r_wide[30:0];
        b_pol_reg.acc    <= cfg.cubic;
    end

    for (genvar k = 0; k < 3; k++)
    begin : g_step
        logic               v_prev;
        ejf_pkg::pol_t      pol_prev;
        logic signed [63:0] prod;
        logic [48:0]        total;
        logic [32:0]        clamped;
        ejf_pkg::pol_t      a_pol_next;

        if (k == 0)
        begin : g_first
            assign v_prev   = b_v_reg;
            assign pol_prev = b_pol_reg;
        end
        else
        begin : g_next
            assign v_prev   = a_v_reg[k-1];
            assign pol_prev = a_pol_reg[k-1];
        end

        assign prod    = pol_prev.acc * $signed({1'b0, pol_prev.r});
        assign total   = {m_prod_reg[k][63], m_prod_reg[k][63:16]}
                       + {{17{coefs[k][31]}}, coefs[k]};
        assign clamped = ejf_pkg::sat32(total);

        always_comb
        begin
            a_pol_next     = m_pol_reg[k];
            a_pol_next.acc = clamped[31:0];
            a_pol_next.sat = m_pol_reg[k].sat | clamped[32];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                m_v_reg[k] <= 1'b0;
                a_v_reg[k] <= 1'b0;
            end
            else
            begin
                m_v_reg[k] <= v_prev;
                a_v_reg[k] <= m_v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            m_prod_reg[k] <= prod;
            m_pol_reg[k]  <= pol_prev;
            a_pol_reg[k]  <= a_pol_next;
        end
    end

    assign out_valid = a_v_reg[2];
    assign pol       = a_pol_reg[2];

endmodule

`default_nettype wire

FILE: sv/ejf_div.sv
// Force magnitude: |f| * |d| products, then a pipelined restoring divide by length.
// Depends on ejf_pkg.
`default_nettype none

module ejf_div (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  ejf_pkg::pol_t pol,
    output logic          out_valid,
    output ejf_pkg::frc_t frc
);

    localparam int unsigned N = ejf_pkg::DIV_STAGES;

    typedef struct packed {
        logic [31:0] len;
        logic [2:0]  neg;
        logic        active;
        logic        sat;
    } side_t;

    logic [31:0] mag_acc;
    side_t       side_next;

    logic        p_v_reg;
    logic [62:0] p_num_reg [3];
    side_t       p_side_reg;

    logic        v_reg    [N];
    logic [31:0] rem_reg  [N][3];
    logic [31:0] low_reg  [N][3];
    logic [31:0] q_reg    [N][3];
    side_t       side_reg [N];

    assign mag_acc = pol.acc[31] ? (~pol.acc + 32'd1) : pol.acc;

    always_comb
    begin
        side_next.len    = pol.len;
        side_next.neg    = pol.neg ^ {3{pol.acc[31]}};
        side_next.active = pol.active;
        side_next.sat    = pol.sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_v_reg <= 1'b0;
        end
        else
        begin
            p_v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            p_num_reg[i] <= 63'(mag_acc) * 63'(pol.mag[i]);
        end
        p_side_reg <= side_next;
    end

    for (genvar k = 0; k < N; k++)
    begin : g_stage
        logic        v_prev;
        side_t       side_prev;
        logic [31:0] rem_prev [3];
        logic [31:0] low_prev [3];
        logic [31:0] q_prev   [3];
        logic [32:0] rem_sh   [3];
        logic [32:0] delta    [3];
        logic [2:0]  ge;

        if (k == 0)
        begin : g_first
            assign v_prev    = p_v_reg;
            assign side_prev = p_side_reg;
            for (genvar i = 0; i < 3; i++)
            begin : g_lane
                assign rem_prev[i] = {1'b0, p_num_reg[i][62:32]};
                assign low_prev[i] = p_num_reg[i][31:0];
                assign q_prev[i]   = '0;
            end
        end
        else
        begin : g_next
            assign v_prev    = v_reg[k-1];
            assign side_prev = side_reg[k-1];
            for (genvar i = 0; i < 3; i++)
            begin : g_lane
                assign rem_prev[i] = rem_reg[k-1][i];
                assign low_prev[i] = low_reg[k-1][i];
                assign q_prev[i]   = q_reg[k-1][i];
            end
        end

        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                rem_sh[i] = {rem_prev[i], low_prev[i][31]};
                delta[i]  = rem_sh[i] - {1'b0, side_prev.len};
                ge[i]     = rem_sh[i] >= {1'b0, side_prev.len};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else
            begin
                v_reg[k] <= v_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            for (int i = 0; i < 3; i++)
            begin
                rem_reg[k][i] <= ge[i] ? delta[i][31:0] : rem_sh[i][31:0];
                low_reg[k][i] <= {low_prev[i][30:0], 1'b0};
                q_reg[k][i]   <= {q_prev[i][30:0], ge[i]};
            end
            side_reg[k] <= side_prev;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            frc.q[i] = q_reg[N-1][i];
        end
        frc.neg    = side_reg[N-1].neg;
        frc.active = side_reg[N-1].active;
        frc.sat    = side_reg[N-1].sat;
    end

    assign out_valid = v_reg[N-1];

endmodule

`default_nettype wire

FILE: sv/elastic_joint_force.sv
// Pipeline: 76 register stages from the edge that transfers an item to the registered
// done and result outputs.
// Throughput: one item per cycle; busy stays low, start is taken on every cycle.
// Most of the pipeline depth comes from the 32-stage square root and the 32-stage divide, one bit per stage.
// Reset clears the valid pipeline and the configuration registers and drops items in flight.
`default_nettype none

module elastic_joint_force (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  ejf_pkg::in_t   req,
    input  logic           cfg_we,
    input  logic [2:0]     cfg_index,
    input  logic [31:0]    cfg_data,
    output logic           done,
    output ejf_pkg::out_t  result
);

    ejf_pkg::cfg_t cfg_reg;

    logic          f_valid;
    ejf_pkg::geo_t f_geo;
    logic [63:0]   f_sum;
    logic          s_valid;
    logic [31:0]   s_len;
    ejf_pkg::geo_t s_geo;
    logic          h_valid;
    ejf_pkg::pol_t h_pol;
    logic          d_valid;
    ejf_pkg::frc_t d_frc;

    logic [2:0][31:0] val;
    logic [2:0]       clip;
    ejf_pkg::out_t    result_next;
    ejf_pkg::out_t    result_reg;
    logic             done_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ejf_pkg::REG_REST_RADIUS: cfg_reg.rest  <= cfg_data[30:0];
                ejf_pkg::REG_COEF_CUBIC:  cfg_reg.cubic <= cfg_data;
                ejf_pkg::REG_COEF_QUAD:   cfg_reg.quad  <= cfg_data;
                ejf_pkg::REG_COEF_LIN:    cfg_reg.lin   <= cfg_data;
                ejf_pkg::REG_COEF_CONST:  cfg_reg.cst   <= cfg_data;
                default:                  cfg_reg       <= cfg_reg;
            endcase
        end
    end

    ejf_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (start & ~busy),
        .item        (req),
        .rest_radius (cfg_reg.rest),
        .out_valid   (f_valid),
        .geo         (f_geo),
        .sum         (f_sum)
    );

    ejf_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .sum       (f_sum),
        .geo_in    (f_geo),
        .out_valid (s_valid),
        .len       (s_len),
        .geo_out   (s_geo)
    );

    ejf_horner u_horner (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_valid),
        .len       (s_len),
        .geo       (s_geo),
        .cfg       (cfg_reg),
        .out_valid (h_valid),
        .pol       (h_pol)
    );

    ejf_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (h_valid),
        .pol       (h_pol),
        .out_valid (d_valid),
        .frc       (d_frc)
    );

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            clip[i] = 1'b0;
            if (d_frc.neg[i])
            begin
                val[i] = ~d_frc.q[i] + 32'd1;
            end
            else if (d_frc.q[i][31])
            begin
                val[i]  = 32'h7FFF_FFFF;
                clip[i] = 1'b1;
            end
            else
            begin
                val[i] = d_frc.q[i];
            end
        end
        result_next.force_x   = d_frc.active ? val[0] : 32'd0;
        result_next.force_y   = d_frc.active ? val[1] : 32'd0;
        result_next.force_z   = d_frc.active ? val[2] : 32'd0;
        result_next.active    = d_frc.active;
        result_next.saturated = d_frc.active & (d_frc.sat | (|clip));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= d_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

FILE: sv/ejf_check.sv
// Port-level checker for elastic_joint_force and the bind that attaches it.
// Depends on ejf_pkg and on the top level's port names.
`default_nettype none

module ejf_check (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          start,
    input wire logic          busy,
    input wire ejf_pkg::in_t  req,
    input wire logic          done,
    input wire ejf_pkg::out_t result
);

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_done_has_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, ejf_pkg::LATENCY))
        else $error("result without a matching input transfer");

    a_inactive_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.active) |->
            (result.force_x == 32'sd0 && result.force_y == 32'sd0 &&
             result.force_z == 32'sd0 && !result.saturated))
        else $error("inactive result carries force or saturation");

    a_input_known: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> !$isunknown(req))
        else $error("unknown input on transfer");

endmodule

bind elastic_joint_force ejf_check u_check (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .req    (req),
    .done   (done),
    .result (result)
);

`default_nettype wire
